// ----- src/fhbb_pkg.sv -----
// Package for the forward horizontal box blur.
// Holds sizing constants, register indexes and the pixel and control types.
// Depends on nothing.
package fhbb_pkg;

    localparam int MAX_BLUR = 16;
    localparam int MAX_WIDTH = 4096;

    localparam int CHAN_W = 8;
    localparam int NUM_CHAN = 3;
    localparam int QUOT_W = CHAN_W;
    localparam int CNT_W = $clog2(QUOT_W);
    localparam int FILL_W = $clog2(MAX_BLUR + 1);
    localparam int IDX_W = (MAX_BLUR > 1) ? $clog2(MAX_BLUR) : 1;
    localparam int SUM_W = $clog2(MAX_BLUR * 255 + 1) + 1;
    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WIDTH_W = $clog2(MAX_WIDTH + 1);

    localparam int BLUR_REG_W = 5;
    localparam int WIDTH_REG_W = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_BLUR_LEN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH = 2'd1;

    typedef struct packed {
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
    } pixel_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic              last_of_run;
    } pixel_out_t;

    typedef struct packed {
        logic clear;
        logic shift;
        logic write;
    } cell_ctrl_t;

endpackage

// ----- src/fhbb_cell.sv -----
// One cell of the pending-pixel chain.
// Holds one pixel; loads a new pixel, takes its neighbor's pixel or clears.
// Depends on fhbb_pkg.
module fhbb_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fhbb_pkg::cell_ctrl_t ctrl,
    input  fhbb_pkg::pixel_in_t  load_pixel,
    input  fhbb_pkg::pixel_in_t  next_pixel,
    output fhbb_pkg::pixel_in_t  pixel
);

    fhbb_pkg::pixel_in_t pixel_reg;
    fhbb_pkg::pixel_in_t pixel_next;

    always_comb
    begin
        pixel_next = pixel_reg;
        if (ctrl.clear)
        begin
            pixel_next = '0;
        end
        else if (ctrl.write)
        begin
            pixel_next = load_pixel;
        end
        else if (ctrl.shift)
        begin
            pixel_next = next_pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_reg <= '0;
        end
        else
        begin
            pixel_reg <= pixel_next;
        end
    end

    assign pixel = pixel_reg;

endmodule

// ----- src/fhbb_window.sv -----
// Chain of cells holding the pending pixels of a row, oldest at the head.
// A shift moves every pixel one cell toward the head.
// Depends on fhbb_pkg and fhbb_cell.
module fhbb_window (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  logic                          write,
    input  logic                          shift,
    input  logic [fhbb_pkg::IDX_W-1:0]    write_index,
    input  fhbb_pkg::pixel_in_t           write_pixel,
    output fhbb_pkg::pixel_in_t           head_pixel
);

    fhbb_pkg::pixel_in_t  cell_pixel [fhbb_pkg::MAX_BLUR];
    fhbb_pkg::cell_ctrl_t cell_ctrl [fhbb_pkg::MAX_BLUR];

    genvar i;
    generate
        for (i = 0; i < fhbb_pkg::MAX_BLUR; i++)
        begin : g_cell
            fhbb_pkg::pixel_in_t neighbor;

            always_comb
            begin
                cell_ctrl[i].clear = clear;
                cell_ctrl[i].shift = shift;
                cell_ctrl[i].write = write && (write_index == fhbb_pkg::IDX_W'(i));
            end

            if (i == fhbb_pkg::MAX_BLUR - 1)
            begin : g_tail
                assign neighbor = '0;
            end
            else
            begin : g_body
                assign neighbor = cell_pixel[i+1];
            end

            fhbb_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (cell_ctrl[i]),
                .load_pixel (write_pixel),
                .next_pixel (neighbor),
                .pixel      (cell_pixel[i])
            );
        end
    endgenerate

    assign head_pixel = cell_pixel[0];

endmodule

// ----- src/fhbb_divider.sv -----
// Restoring divider for the three channel sums, one quotient bit per cycle.
// The quotient is known to fit one channel, so the high sum bits seed the remainder.
// Depends on fhbb_pkg.
module fhbb_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [fhbb_pkg::SUM_W-1:0]    sum [fhbb_pkg::NUM_CHAN],
    input  logic [fhbb_pkg::FILL_W-1:0]   divisor,
    output logic                          done,
    output logic [fhbb_pkg::QUOT_W-1:0]   quotient [fhbb_pkg::NUM_CHAN]
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [fhbb_pkg::CNT_W-1:0]    cnt_reg;
    logic [fhbb_pkg::FILL_W-1:0]   divisor_reg;
    logic [fhbb_pkg::FILL_W-1:0]   rem_reg [fhbb_pkg::NUM_CHAN];
    logic [fhbb_pkg::QUOT_W-1:0]   quo_reg [fhbb_pkg::NUM_CHAN];
    logic [fhbb_pkg::FILL_W-1:0]   rem_next [fhbb_pkg::NUM_CHAN];
    logic [fhbb_pkg::QUOT_W-1:0]   quo_next [fhbb_pkg::NUM_CHAN];

    always_comb
    begin
        for (int c = 0; c < fhbb_pkg::NUM_CHAN; c++)
        begin
            logic [fhbb_pkg::FILL_W:0] trial;
            logic                      ge;
            trial = {rem_reg[c], quo_reg[c][fhbb_pkg::QUOT_W-1]};
            ge = (trial >= {1'b0, divisor_reg});
            rem_next[c] = ge ? fhbb_pkg::FILL_W'(trial - {1'b0, divisor_reg})
                             : fhbb_pkg::FILL_W'(trial);
            quo_next[c] = {quo_reg[c][fhbb_pkg::QUOT_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + fhbb_pkg::CNT_W'(1);
            if (cnt_reg == fhbb_pkg::CNT_W'(fhbb_pkg::QUOT_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            divisor_reg <= divisor;
            for (int c = 0; c < fhbb_pkg::NUM_CHAN; c++)
            begin
                rem_reg[c] <= fhbb_pkg::FILL_W'(sum[c] >> fhbb_pkg::QUOT_W);
                quo_reg[c] <= sum[c][fhbb_pkg::QUOT_W-1:0];
            end
        end
        else if (busy_reg)
        begin
            for (int c = 0; c < fhbb_pkg::NUM_CHAN; c++)
            begin
                rem_reg[c] <= rem_next[c];
                quo_reg[c] <= quo_next[c];
            end
        end
    end

    assign done = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- src/forward_horizontal_box_blur.sv -----
// Top level of the forward horizontal box blur: control, sums and output register.
// Depends on fhbb_pkg, fhbb_window and fhbb_divider.
//
//   Channel  Signals                                Content
//   pixel    pixel_valid, pixel_ready, pixel        one RGB pixel in raster order
//   result   result_valid, result_ready, result     one averaged pixel and last_of_run
//   cfg      cfg_valid, cfg_ready, cfg_index/data   blur length (0), image width (1)
//
// A pixel that completes no window leaves the block ready for the next pixel.
// Each result passes through the start state and the eight steps of the shared divider.
// A row end gives one result per pending pixel.
// A pixel transaction is taken while a finished result still waits in the output register.
// Reset and a write to either register empty the window and restart at column zero.
module forward_horizontal_box_blur (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pixel_valid,
    output logic                              pixel_ready,
    input  fhbb_pkg::pixel_in_t               pixel,
    output logic                              result_valid,
    input  logic                              result_ready,
    output fhbb_pkg::pixel_out_t              result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fhbb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fhbb_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_DIV = 2'd2;

    logic [1:0]                        state_reg;
    logic [1:0]                        state_next;
    logic [fhbb_pkg::BLUR_REG_W-1:0]   blur_len_reg;
    logic [fhbb_pkg::WIDTH_REG_W-1:0]  image_width_reg;
    logic [fhbb_pkg::FILL_W-1:0]       fill_reg;
    logic [fhbb_pkg::FILL_W-1:0]       fill_next;
    logic [fhbb_pkg::COL_W-1:0]        column_reg;
    logic [fhbb_pkg::COL_W-1:0]        column_next;
    logic                              flush_reg;
    logic                              flush_next;
    logic [fhbb_pkg::SUM_W-1:0]        sum_reg [fhbb_pkg::NUM_CHAN];
    logic [fhbb_pkg::SUM_W-1:0]        sum_next [fhbb_pkg::NUM_CHAN];
    logic                              result_valid_reg;
    logic                              result_valid_next;
    fhbb_pkg::pixel_out_t              result_reg;
    fhbb_pkg::pixel_out_t              result_next;

    logic [fhbb_pkg::FILL_W-1:0]       blur_eff;
    logic [fhbb_pkg::WIDTH_W-1:0]      width_eff;
    logic [fhbb_pkg::FILL_W-1:0]       fill_inc;
    logic                              pixel_fire;
    logic                              cfg_clear;
    logic                              more_flush;
    logic [fhbb_pkg::CHAN_W-1:0]       in_chan [fhbb_pkg::NUM_CHAN];
    logic [fhbb_pkg::CHAN_W-1:0]       head_chan [fhbb_pkg::NUM_CHAN];

    logic                              win_clear;
    logic                              win_write;
    logic                              win_shift;
    fhbb_pkg::pixel_in_t               head_pixel;
    logic                              div_start;
    logic                              div_done;
    logic [fhbb_pkg::QUOT_W-1:0]       div_quot [fhbb_pkg::NUM_CHAN];

    assign pixel_ready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign pixel_fire = pixel_valid && pixel_ready;
    assign cfg_clear = cfg_valid
                    && (cfg_index inside {fhbb_pkg::REG_BLUR_LEN, fhbb_pkg::REG_IMAGE_WIDTH});

    assign in_chan[0] = pixel.red_in;
    assign in_chan[1] = pixel.green_in;
    assign in_chan[2] = pixel.blue_in;
    assign head_chan[0] = head_pixel.red_in;
    assign head_chan[1] = head_pixel.green_in;
    assign head_chan[2] = head_pixel.blue_in;

    always_comb
    begin
        if (blur_len_reg == '0)
        begin
            blur_eff = fhbb_pkg::FILL_W'(1);
        end
        else if (32'(blur_len_reg) > fhbb_pkg::MAX_BLUR)
        begin
            blur_eff = fhbb_pkg::FILL_W'(fhbb_pkg::MAX_BLUR);
        end
        else
        begin
            blur_eff = fhbb_pkg::FILL_W'(blur_len_reg);
        end

        if (image_width_reg == '0)
        begin
            width_eff = fhbb_pkg::WIDTH_W'(1);
        end
        else if (32'(image_width_reg) > fhbb_pkg::MAX_WIDTH)
        begin
            width_eff = fhbb_pkg::WIDTH_W'(fhbb_pkg::MAX_WIDTH);
        end
        else
        begin
            width_eff = fhbb_pkg::WIDTH_W'(image_width_reg);
        end
    end

    assign fill_inc = fill_reg + fhbb_pkg::FILL_W'(1);
    assign more_flush = flush_reg && (fill_reg > fhbb_pkg::FILL_W'(1));

    always_comb
    begin
        state_next = state_reg;
        fill_next = fill_reg;
        column_next = column_reg;
        flush_next = flush_reg;
        sum_next = sum_reg;
        result_valid_next = result_valid_reg;
        result_next = result_reg;
        win_clear = 1'b0;
        win_write = 1'b0;
        win_shift = 1'b0;
        div_start = 1'b0;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (pixel_fire)
                begin
                    win_write = 1'b1;
                    fill_next = fill_inc;
                    for (int c = 0; c < fhbb_pkg::NUM_CHAN; c++)
                    begin
                        sum_next[c] = sum_reg[c] + fhbb_pkg::SUM_W'(in_chan[c]);
                    end
                    if (32'(column_reg) + 1 >= 32'(width_eff))
                    begin
                        flush_next = 1'b1;
                        column_next = '0;
                        state_next = ST_START;
                    end
                    else
                    begin
                        flush_next = 1'b0;
                        column_next = column_reg + fhbb_pkg::COL_W'(1);
                        if (fill_inc >= blur_eff)
                        begin
                            state_next = ST_START;
                        end
                    end
                end
            end
            ST_START:
            begin
                div_start = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done && (!result_valid_reg || result_ready))
                begin
                    result_valid_next = 1'b1;
                    result_next.red_out = div_quot[0];
                    result_next.green_out = div_quot[1];
                    result_next.blue_out = div_quot[2];
                    result_next.last_of_run = !more_flush;
                    win_shift = 1'b1;
                    fill_next = fill_reg - fhbb_pkg::FILL_W'(1);
                    for (int c = 0; c < fhbb_pkg::NUM_CHAN; c++)
                    begin
                        sum_next[c] = sum_reg[c] - fhbb_pkg::SUM_W'(head_chan[c]);
                    end
                    state_next = more_flush ? ST_START : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_clear)
        begin
            win_clear = 1'b1;
            win_write = 1'b0;
            win_shift = 1'b0;
            fill_next = '0;
            column_next = '0;
            flush_next = 1'b0;
            for (int c = 0; c < fhbb_pkg::NUM_CHAN; c++)
            begin
                sum_next[c] = '0;
            end
            state_next = ST_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            blur_len_reg <= fhbb_pkg::BLUR_REG_W'(1);
            image_width_reg <= fhbb_pkg::WIDTH_REG_W'(1);
            fill_reg <= '0;
            column_reg <= '0;
            flush_reg <= 1'b0;
            result_valid_reg <= 1'b0;
            for (int c = 0; c < fhbb_pkg::NUM_CHAN; c++)
            begin
                sum_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            column_reg <= column_next;
            flush_reg <= flush_next;
            result_valid_reg <= result_valid_next;
            sum_reg <= sum_next;
            if (cfg_valid && (cfg_index == fhbb_pkg::REG_BLUR_LEN))
            begin
                blur_len_reg <= cfg_data[fhbb_pkg::BLUR_REG_W-1:0];
            end
            if (cfg_valid && (cfg_index == fhbb_pkg::REG_IMAGE_WIDTH))
            begin
                image_width_reg <= cfg_data[fhbb_pkg::WIDTH_REG_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    fhbb_window u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (win_clear),
        .write       (win_write),
        .shift       (win_shift),
        .write_index (fill_reg[fhbb_pkg::IDX_W-1:0]),
        .write_pixel (pixel),
        .head_pixel  (head_pixel)
    );

    fhbb_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .sum      (sum_reg),
        .divisor  (fill_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign result_valid = result_valid_reg;
    assign result = result_reg;

endmodule
